// ===== hdl/cpfc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpfc_pkg: shared types, codes and the CRC16 byte update
// Types and constants used by the packet framer and checker modules.
// ----------------------------------------------------------------------------
package cpfc_pkg;

    localparam int unsigned MAX_RESULTS = 5;
    localparam int unsigned CNT_W       = $clog2(MAX_RESULTS + 1);

    localparam logic [15:0] CRC_POLY        = 16'h8005;
    localparam logic [7:0]  ABS_MAX_PAYLOAD = 8'd251;
    localparam logic [7:0]  HEADER_EXTRA    = 8'd3;
    localparam logic [7:0]  MIN_RSP_LEN     = 8'd4;

    localparam logic [7:0] RST_COMMAND_WORD = 8'd3;
    localparam logic [7:0] RST_MIN_PAYLOAD  = 8'd4;
    localparam logic [7:0] RST_MAX_PAYLOAD  = 8'd251;
    localparam logic [7:0] RST_WAKE_OK_CODE = 8'd17;

    localparam logic [7:0] REG_COMMAND_WORD = 8'd0;
    localparam logic [7:0] REG_MIN_PAYLOAD  = 8'd1;
    localparam logic [7:0] REG_MAX_PAYLOAD  = 8'd2;
    localparam logic [7:0] REG_WAKE_OK_CODE = 8'd3;

    localparam logic [1:0] KIND_CMD     = 2'd0;
    localparam logic [1:0] KIND_RSP     = 2'd1;
    localparam logic [1:0] KIND_VERDICT = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_SIZE      = 3'd1;
    localparam logic [2:0] ST_SHORT     = 3'd2;
    localparam logic [2:0] ST_CRC       = 3'd3;
    localparam logic [2:0] ST_WAKE_CODE = 3'd4;

    typedef enum logic [1:0] {
        OP_CMD  = 2'd0,
        OP_RSP  = 2'd1,
        OP_WAKE = 2'd2,
        OP_NONE = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_CMD  = 2'd1,
        PH_RSP  = 2'd2,
        PH_WAKE = 2'd3
    } t_phase;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] data;
        logic [7:0] payload_len;
    } t_item;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] out_byte;
        logic [2:0] status;
        logic       last;
    } t_result;

    typedef struct packed {
        logic [CNT_W-1:0]               cnt;
        t_result [MAX_RESULTS-1:0]      res;
    } t_burst;

    typedef struct packed {
        logic can_load;
        logic load;
    } t_buf_ctrl;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc;
        for (int i = 0; i < 8; i++) begin
            if (b[i] ^ c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== hdl/cpfc_in_reg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpfc_in_reg: input word register
// Holds one accepted input word until the core takes it.
// ----------------------------------------------------------------------------
module cpfc_in_reg
    import cpfc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    input  logic  i_take,
    output logic  o_valid,
    output t_item o_item
);

    logic  r_valid;
    t_item r_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

endmodule

// ===== hdl/cpfc_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpfc_core: framing and checking logic
// Holds the configuration and packet state and turns one input word into its
// group of result words.
// ----------------------------------------------------------------------------
module cpfc_core
    import cpfc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    input  logic       i_valid,
    input  t_item      i_item,
    input  logic       i_can_load,
    output logic       o_take,
    output t_burst     o_burst
);

    logic [7:0]  r_command_word;
    logic [7:0]  r_min_payload;
    logic [7:0]  r_max_payload;
    logic [7:0]  r_wake_ok_code;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_pos, n_pos;
    logic [7:0]  r_total, n_total;
    logic [15:0] r_crc, n_crc;
    logic [7:0]  r_held, n_held;
    logic        r_seen, n_seen;

    t_burst      n_burst;

    function automatic t_result mk_res(input logic [1:0] kind, input logic [7:0] b,
                                       input logic [2:0] st, input logic last);
        t_result r;
        r.kind     = kind;
        r.out_byte = b;
        r.status   = st;
        r.last     = last;
        return r;
    endfunction

    always_comb begin
        t_phase      ph;
        logic [7:0]  maxp;
        logic        size_bad;
        logic        do_data;
        logic [2:0]  base;
        logic [15:0] crc_base;
        logic [7:0]  pos_base;
        logic [15:0] got;
        n_phase  = r_phase;
        n_pos    = r_pos;
        n_total  = r_total;
        n_crc    = r_crc;
        n_held   = r_held;
        n_seen   = r_seen;
        n_burst  = '0;
        do_data  = 1'b0;
        base     = 3'd0;
        crc_base = r_crc;
        pos_base = r_pos;
        got      = {i_item.data, r_held};
        maxp     = (r_max_payload < ABS_MAX_PAYLOAD) ? r_max_payload : ABS_MAX_PAYLOAD;
        size_bad = (i_item.payload_len == 8'd0) || (i_item.payload_len < r_min_payload)
                   || (i_item.payload_len > maxp);
        ph = ((r_phase != PH_IDLE) && (r_phase != t_phase'(i_item.op + 2'd1))) ?
             PH_IDLE : r_phase;

        unique case (t_op'(i_item.op))
            OP_CMD: begin
                n_phase = ph;
                if (ph == PH_IDLE) begin
                    if (size_bad) begin
                        n_burst.res[0] = mk_res(KIND_VERDICT, 8'd0, ST_SIZE, 1'b1);
                        n_burst.cnt    = CNT_W'(1);
                        if (i_item.payload_len > 8'd1) begin
                            n_phase = PH_CMD;
                            n_total = 8'd0;
                            n_pos   = i_item.payload_len - 8'd1;
                        end
                    end else begin
                        n_total        = i_item.payload_len + HEADER_EXTRA;
                        crc_base       = crc_byte(16'd0, n_total);
                        pos_base       = 8'd0;
                        n_phase        = PH_CMD;
                        n_burst.res[0] = mk_res(KIND_CMD, r_command_word, ST_OK, 1'b0);
                        n_burst.res[1] = mk_res(KIND_CMD, n_total, ST_OK, 1'b0);
                        base           = 3'd2;
                        do_data        = 1'b1;
                    end
                end else if (r_total == 8'd0) begin
                    n_pos = r_pos - 8'd1;
                    if (n_pos == 8'd0) begin
                        n_phase = PH_IDLE;
                    end
                end else begin
                    do_data = 1'b1;
                end
                if (do_data) begin
                    n_crc             = crc_byte(crc_base, i_item.data);
                    n_pos             = pos_base + 8'd1;
                    n_burst.res[base] = mk_res(KIND_CMD, i_item.data, ST_OK, 1'b0);
                    if ({1'b0, n_pos} + 9'd3 >= {1'b0, n_total}) begin
                        n_burst.res[base + 3'd1] = mk_res(KIND_CMD, n_crc[7:0], ST_OK, 1'b0);
                        n_burst.res[base + 3'd2] = mk_res(KIND_CMD, n_crc[15:8], ST_OK, 1'b1);
                        n_burst.cnt              = CNT_W'(base + 3'd3);
                        n_phase                  = PH_IDLE;
                    end else begin
                        n_burst.cnt = CNT_W'(base + 3'd1);
                    end
                end
            end
            OP_RSP: begin
                n_phase = ph;
                if (ph == PH_IDLE) begin
                    if (i_item.data < MIN_RSP_LEN) begin
                        n_burst.res[0] = mk_res(KIND_VERDICT, 8'd0, ST_SHORT, 1'b1);
                        n_burst.cnt    = CNT_W'(1);
                    end else begin
                        n_total = i_item.data;
                        n_crc   = crc_byte(16'd0, i_item.data);
                        n_pos   = 8'd1;
                        n_phase = PH_RSP;
                    end
                end else if ({1'b0, r_pos} + 9'd2 < {1'b0, r_total}) begin
                    n_crc          = crc_byte(r_crc, i_item.data);
                    n_burst.res[0] = mk_res(KIND_RSP, i_item.data, ST_OK, 1'b0);
                    n_burst.cnt    = CNT_W'(1);
                    n_pos          = r_pos + 8'd1;
                end else if ({1'b0, r_pos} + 9'd2 == {1'b0, r_total}) begin
                    n_held = i_item.data;
                    n_pos  = r_pos + 8'd1;
                end else begin
                    n_burst.res[0] = mk_res(KIND_VERDICT, 8'd0,
                                            (got == r_crc) ? ST_OK : ST_CRC, 1'b1);
                    n_burst.cnt    = CNT_W'(1);
                    n_phase        = PH_IDLE;
                end
            end
            OP_WAKE: begin
                n_phase = ph;
                if (ph == PH_IDLE) begin
                    n_crc   = crc_byte(16'd0, i_item.data);
                    n_pos   = 8'd1;
                    n_phase = PH_WAKE;
                end else if (r_pos == 8'd1) begin
                    n_crc  = crc_byte(r_crc, i_item.data);
                    n_seen = (i_item.data == r_wake_ok_code);
                    n_pos  = 8'd2;
                end else if (r_pos == 8'd2) begin
                    n_held = i_item.data;
                    n_pos  = 8'd3;
                end else begin
                    n_burst.res[0] = mk_res(KIND_VERDICT, 8'd0,
                                            (got != r_crc) ? ST_CRC :
                                            (r_seen ? ST_OK : ST_WAKE_CODE), 1'b1);
                    n_burst.cnt    = CNT_W'(1);
                    n_phase        = PH_IDLE;
                end
            end
            OP_NONE: begin
                n_phase = r_phase;
            end
            default: begin
                n_phase = r_phase;
            end
        endcase
    end

    assign o_take  = i_valid && ((n_burst.cnt == '0) || i_can_load);
    assign o_burst = n_burst;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_command_word <= RST_COMMAND_WORD;
            r_min_payload  <= RST_MIN_PAYLOAD;
            r_max_payload  <= RST_MAX_PAYLOAD;
            r_wake_ok_code <= RST_WAKE_OK_CODE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_COMMAND_WORD: r_command_word <= i_cfg_data;
                REG_MIN_PAYLOAD:  r_min_payload  <= i_cfg_data;
                REG_MAX_PAYLOAD:  r_max_payload  <= i_cfg_data;
                REG_WAKE_OK_CODE: r_wake_ok_code <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_pos   <= 8'd0;
            r_total <= 8'd0;
            r_crc   <= 16'd0;
            r_held  <= 8'd0;
            r_seen  <= 1'b0;
        end else if (o_take) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_total <= n_total;
            r_crc   <= n_crc;
            r_held  <= n_held;
            r_seen  <= n_seen;
        end
    end

endmodule

// ===== hdl/cpfc_out_buf.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpfc_out_buf: result word buffer
// Loads a group of result words at once and shifts them out one word a cycle while i_ready is high.
// ----------------------------------------------------------------------------
module cpfc_out_buf
    import cpfc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_burst    i_burst,
    input  logic      i_load,
    input  logic      i_ready,
    output logic      o_valid,
    output t_result   o_res,
    output t_buf_ctrl o_ctrl
);

    logic [CNT_W-1:0]          r_cnt;
    t_result [MAX_RESULTS-1:0] r_q;
    logic                      pop;

    assign o_valid         = (r_cnt != '0);
    assign o_res           = r_q[0];
    assign pop             = o_valid && i_ready;
    assign o_ctrl.can_load = (r_cnt == '0) || ((r_cnt == CNT_W'(1)) && pop);
    assign o_ctrl.load     = i_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= i_burst.cnt;
        end else if (pop) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_q <= i_burst.res;
        end else if (pop) begin
            r_q <= {t_result'('0), r_q[MAX_RESULTS-1:1]};
        end
    end

endmodule

// ===== hdl/crypto_chip_packet_framer_checker_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crypto_chip_packet_framer_checker_core: command framer and response checker
// Frames command packets with word, length and CRC16, and checks response and
// wake reply packets against their CRC16.
//
// Channel   Direction  Word contents
// s_axis    in         tuser op, tdata data and payload length
// m_axis    out        tuser kind, tdata byte and status, tlast end of packet
// cfg       in         register index and 8-bit register value
//
// An input word that yields at most one result word is taken every cycle while m_axis accepts.
// A word that yields k result words holds back the next word that has results
// while the result buffer drains one word per cycle whenever m_axis is ready.
// The first result word of an input word is registered in the result buffer when the core takes it.
// Reset is synchronous and restores the register defaults and idle state.
// A stalled m_axis holds its word, and s_axis keeps one word in its register.
// ----------------------------------------------------------------------------
module crypto_chip_packet_framer_checker_core
    import cpfc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // data [7:0], payload_len [15:8]
    input  logic [1:0]  s_axis_tuser,   // op [1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // out_byte [7:0], status [10:8], zero [15:11]
    output logic [1:0]  m_axis_tuser,   // out_kind [1:0]
    output logic        m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    t_item     in_item;
    t_item     reg_item;
    logic      reg_valid;
    logic      take;
    t_burst    burst;
    t_result   res;
    t_buf_ctrl buf_ctrl;

    assign in_item.op          = s_axis_tuser;
    assign in_item.data        = s_axis_tdata[7:0];
    assign in_item.payload_len = s_axis_tdata[15:8];
    assign o_cfg_ready         = 1'b1;

    cpfc_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_item  (in_item),
        .i_take  (take),
        .o_valid (reg_valid),
        .o_item  (reg_item)
    );

    cpfc_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (reg_valid),
        .i_item      (reg_item),
        .i_can_load  (buf_ctrl.can_load),
        .o_take      (take),
        .o_burst     (burst)
    );

    cpfc_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_burst (burst),
        .i_load  (take && (burst.cnt != '0)),
        .i_ready (m_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_res   (res),
        .o_ctrl  (buf_ctrl)
    );

    assign m_axis_tdata = {5'd0, res.status, res.out_byte};
    assign m_axis_tuser = res.kind;
    assign m_axis_tlast = res.last;

endmodule

// ===== hdl/cpfc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpfc_checker: port-level assertions
// Checks the result words seen on the top-level ports.
// ----------------------------------------------------------------------------
module cpfc_checker
    import cpfc_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("Stalled result word changed.");

    a_verdict_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == KIND_VERDICT) |-> m_axis_tlast)
        else $error("Verdict word without tlast.");

    a_verdict_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == KIND_VERDICT) |-> (m_axis_tdata[7:0] == 8'd0))
        else $error("Verdict word carries a nonzero byte.");

    a_data_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser != KIND_VERDICT) |-> (m_axis_tdata[10:8] == ST_OK))
        else $error("Data word carries a nonzero status.");

    a_rsp_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == KIND_RSP) |-> !m_axis_tlast)
        else $error("Response payload word marked last.");

endmodule

bind crypto_chip_packet_framer_checker_core cpfc_checker u_cpfc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

// ===== test/tb_crypto_chip_packet_framer_checker_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_crypto_chip_packet_framer_checker_core: self-checking testbench
// Drives command, response and wake reply words into the framer and checker,
// predicts the result words with a behavioral model of the block or a directed table, and
// compares each accepted result word field by field, under several register
// settings and with random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_crypto_chip_packet_framer_checker_core;
    import cpfc_pkg::*;

    localparam int QUIET = 16;
    localparam int LIMIT = 400000;

    typedef struct {
        logic [1:0] op;
        logic [7:0] d;
        logic [7:0] plen;
        bit         typed;
        logic [2:0] st;
    } t_row;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;
    logic [1:0]  s_axis_tuser  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_index   = '0;
    logic [7:0]  i_cfg_data    = '0;

    logic [7:0]  reg_word, reg_min, reg_max, reg_wake;
    t_phase      m_phase;
    logic [7:0]  m_pos, m_total, m_held;
    logic [15:0] m_crc;
    logic        m_seen;

    t_result     want_q[$];
    t_result     fresh_q[$];
    bit          typed_on = 1'b0;
    t_result     typed_res;
    t_row        dir_tab[$];
    int          errors     = 0;
    int          cycles     = 0;
    int          items_sent = 0;
    int          idle_pct   = 0;
    int          stall_pct  = 0;

    crypto_chip_packet_framer_checker_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("tb_crypto_chip_packet_framer_checker_core NOT OK");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    function automatic logic [15:0] crc16_update(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        logic        fb;
        r = c;
        for (int i = 0; i < 8; i++) begin
            fb = b[i] ^ r[15];
            r  = r << 1;
            if (fb) begin
                r = r ^ CRC_POLY;
            end
        end
        return r;
    endfunction

    function automatic void post_result(input logic [1:0] kind, input logic [7:0] b,
                                        input logic [2:0] st, input logic last);
        fresh_q.push_back('{kind, b, st, last});
    endfunction

    function automatic void frame_and_check(input logic [1:0] op, input logic [7:0] d,
                                            input logic [7:0] plen);
        logic [7:0]  lim;
        logic [15:0] got;
        t_op         o;
        o = t_op'(op);
        if (o == OP_NONE) begin
            return;
        end
        if (m_phase != PH_IDLE && m_phase != t_phase'(op + 2'd1)) begin
            m_phase = PH_IDLE;
        end
        case (o)
            OP_CMD: begin
                if (m_phase == PH_IDLE) begin
                    lim = (reg_max < ABS_MAX_PAYLOAD) ? reg_max : ABS_MAX_PAYLOAD;
                    if (plen == 8'd0 || plen < reg_min || plen > lim) begin
                        post_result(KIND_VERDICT, 8'h00, ST_SIZE, 1'b1);
                        if (plen > 8'd1) begin
                            m_phase = PH_CMD;
                            m_total = 8'd0;
                            m_pos   = plen - 8'd1;
                        end
                        return;
                    end
                    m_total = plen + HEADER_EXTRA;
                    m_crc   = crc16_update(16'h0000, m_total);
                    m_pos   = 8'd0;
                    m_phase = PH_CMD;
                    post_result(KIND_CMD, reg_word, ST_OK, 1'b0);
                    post_result(KIND_CMD, m_total, ST_OK, 1'b0);
                end else if (m_total == 8'd0) begin
                    m_pos = m_pos - 8'd1;
                    if (m_pos == 8'd0) begin
                        m_phase = PH_IDLE;
                    end
                    return;
                end
                m_crc = crc16_update(m_crc, d);
                m_pos = m_pos + 8'd1;
                post_result(KIND_CMD, d, ST_OK, 1'b0);
                if (int'(m_pos) + 3 >= int'(m_total)) begin
                    post_result(KIND_CMD, m_crc[7:0], ST_OK, 1'b0);
                    post_result(KIND_CMD, m_crc[15:8], ST_OK, 1'b1);
                    m_phase = PH_IDLE;
                end
            end
            OP_RSP: begin
                if (m_phase == PH_IDLE) begin
                    if (d < MIN_RSP_LEN) begin
                        post_result(KIND_VERDICT, 8'h00, ST_SHORT, 1'b1);
                        return;
                    end
                    m_total = d;
                    m_crc   = crc16_update(16'h0000, d);
                    m_pos   = 8'd1;
                    m_phase = PH_RSP;
                    return;
                end
                if (int'(m_pos) + 2 < int'(m_total)) begin
                    m_crc = crc16_update(m_crc, d);
                    post_result(KIND_RSP, d, ST_OK, 1'b0);
                end else if (int'(m_pos) + 2 == int'(m_total)) begin
                    m_held = d;
                end else begin
                    got = {d, m_held};
                    post_result(KIND_VERDICT, 8'h00, (got == m_crc) ? ST_OK : ST_CRC, 1'b1);
                    m_phase = PH_IDLE;
                    return;
                end
                m_pos = m_pos + 8'd1;
            end
            default: begin
                if (m_phase == PH_IDLE) begin
                    m_crc   = crc16_update(16'h0000, d);
                    m_pos   = 8'd1;
                    m_phase = PH_WAKE;
                end else if (m_pos == 8'd1) begin
                    m_crc  = crc16_update(m_crc, d);
                    m_seen = (d == reg_wake);
                    m_pos  = 8'd2;
                end else if (m_pos == 8'd2) begin
                    m_held = d;
                    m_pos  = 8'd3;
                end else begin
                    got = {d, m_held};
                    post_result(KIND_VERDICT, 8'h00,
                                (got != m_crc) ? ST_CRC : (m_seen ? ST_OK : ST_WAKE_CODE), 1'b1);
                    m_phase = PH_IDLE;
                end
            end
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [15:0] exp_v,
                                        input logic [15:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            errors++;
        end
    endfunction

    always @(posedge i_clk) begin : monitor
        t_result w;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                fresh_q.delete();
                frame_and_check(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[15:8]);
                if (typed_on) begin
                    want_q.push_back(typed_res);
                    typed_on = 1'b0;
                end else begin
                    foreach (fresh_q[k]) begin
                        want_q.push_back(fresh_q[k]);
                    end
                end
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (want_q.size() == 0) begin
                    $error("out_kind: expected no word, got %0d", m_axis_tuser);
                    errors++;
                end else begin
                    w = want_q.pop_front();
                    check_field("out_kind", 16'(w.kind), 16'(m_axis_tuser));
                    check_field("out_byte", 16'(w.out_byte), 16'(m_axis_tdata[7:0]));
                    check_field("status", 16'(w.status), 16'(m_axis_tdata[10:8]));
                    check_field("pad", 16'd0, 16'(m_axis_tdata[15:11]));
                    check_field("last", 16'(w.last), 16'(m_axis_tlast));
                end
            end
        end
    end

    task automatic send_word(input logic [1:0] op, input logic [7:0] d, input logic [7:0] plen,
                             input bit typed, input logic [2:0] st);
        while ($urandom_range(99) < idle_pct) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {plen, d};
        s_axis_tuser  <= op;
        typed_on  = typed;
        typed_res = '{KIND_VERDICT, 8'h00, st, 1'b1};
        do @(posedge i_clk); while (!s_axis_tready);
        if (op != OP_NONE) begin
            items_sent++;
        end
    endtask

    task automatic send_bytes(input logic [1:0] op, input logic [7:0] pkt[$], input int cnt);
        for (int k = 0; k < cnt; k++) begin
            send_word(op, pkt[k], 8'($urandom), 1'b0, ST_OK);
        end
    endtask

    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (want_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (QUIET) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_COMMAND_WORD: reg_word = val;
            REG_MIN_PAYLOAD:  reg_min  = val;
            REG_MAX_PAYLOAD:  reg_max  = val;
            REG_WAKE_OK_CODE: reg_wake = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic write_all(input logic [7:0] w, input logic [7:0] mn, input logic [7:0] mx,
                             input logic [7:0] wk);
        write_reg(REG_COMMAND_WORD, w);
        write_reg(REG_MIN_PAYLOAD, mn);
        write_reg(REG_MAX_PAYLOAD, mx);
        write_reg(REG_WAKE_OK_CODE, wk);
    endtask

    task automatic rand_command();
        int lo, hi, n, cnt;
        lo = (reg_min == 8'd0) ? 1 : int'(reg_min);
        hi = (reg_max < ABS_MAX_PAYLOAD) ? int'(reg_max) : int'(ABS_MAX_PAYLOAD);
        if (lo <= hi && $urandom_range(99) < 75) begin
            if ($urandom_range(9) == 0) begin
                n = $urandom_range(hi, lo);
            end else begin
                n = $urandom_range((lo + 10 < hi) ? lo + 10 : hi, lo);
            end
            cnt = ($urandom_range(9) == 0) ? $urandom_range(n, 1) : n;
        end else begin
            case ($urandom_range(3))
                0:       n = 0;
                1:       n = (lo > 1) ? $urandom_range(lo - 1, 1) : 0;
                2:       n = (hi < 255) ? $urandom_range(255, hi + 1) : 0;
                default: n = $urandom_range(255, 252);
            endcase
            if (n == 0) begin
                cnt = 1;
            end else begin
                cnt = (n <= 24) ? n : $urandom_range(4, 1);
            end
        end
        if (cnt > 24) begin
            cnt = $urandom_range(24, 1);
        end
        for (int k = 0; k < cnt; k++) begin
            send_word(OP_CMD, 8'($urandom), (k == 0) ? 8'(n) : 8'($urandom), 1'b0, ST_OK);
        end
    endtask

    task automatic rand_response();
        int          len;
        logic [15:0] c;
        logic [7:0]  b;
        logic [7:0]  pkt[$];
        if ($urandom_range(9) == 0) begin
            send_word(OP_RSP, 8'($urandom_range(3, 0)), 8'($urandom), 1'b0, ST_OK);
            return;
        end
        len = ($urandom_range(24) == 0) ? $urandom_range(30, 15) : $urandom_range(14, 4);
        c = crc16_update(16'h0000, 8'(len));
        pkt.push_back(8'(len));
        for (int k = 1; k < len - 2; k++) begin
            b = 8'($urandom);
            c = crc16_update(c, b);
            pkt.push_back(b);
        end
        if ($urandom_range(4) == 0) begin
            c = c ^ (16'h0001 << $urandom_range(15, 0));
        end
        pkt.push_back(c[7:0]);
        pkt.push_back(c[15:8]);
        send_bytes(OP_RSP, pkt, ($urandom_range(11) == 0) ? $urandom_range(len - 1, 1) : len);
    endtask

    task automatic rand_wake();
        logic [15:0] c;
        logic [7:0]  b0, b1;
        logic [7:0]  pkt[$];
        b0 = 8'($urandom);
        b1 = ($urandom_range(9) < 7) ? reg_wake : 8'($urandom);
        c  = crc16_update(crc16_update(16'h0000, b0), b1);
        if ($urandom_range(4) == 0) begin
            c = c ^ (16'h0001 << $urandom_range(15, 0));
        end
        pkt = '{b0, b1, c[7:0], c[15:8]};
        send_bytes(OP_WAKE, pkt, ($urandom_range(11) == 0) ? $urandom_range(3, 1) : 4);
    endtask

    initial begin : stim
        logic [15:0] c;
        int          pick, start;
        reg_word = RST_COMMAND_WORD;
        reg_min  = RST_MIN_PAYLOAD;
        reg_max  = RST_MAX_PAYLOAD;
        reg_wake = RST_WAKE_OK_CODE;
        m_phase  = PH_IDLE;
        m_pos    = '0;
        m_total  = '0;
        m_crc    = '0;
        m_held   = '0;
        m_seen   = 1'b0;

        dir_tab.push_back('{OP_CMD,  8'h00, 8'd0,   1'b1, ST_SIZE});
        dir_tab.push_back('{OP_CMD,  8'hFF, 8'd1,   1'b1, ST_SIZE});
        dir_tab.push_back('{OP_CMD,  8'h12, 8'd3,   1'b1, ST_SIZE});
        dir_tab.push_back('{OP_CMD,  8'h34, 8'd0,   1'b0, ST_OK});
        dir_tab.push_back('{OP_CMD,  8'h56, 8'd0,   1'b0, ST_OK});
        dir_tab.push_back('{OP_CMD,  8'hFF, 8'd252, 1'b1, ST_SIZE});
        dir_tab.push_back('{OP_RSP,  8'h00, 8'd0,   1'b1, ST_SHORT});
        dir_tab.push_back('{OP_RSP,  8'h03, 8'hFF,  1'b1, ST_SHORT});
        dir_tab.push_back('{OP_NONE, 8'hFF, 8'hFF,  1'b0, ST_OK});
        dir_tab.push_back('{OP_CMD,  8'h00, 8'd4,   1'b0, ST_OK});
        dir_tab.push_back('{OP_CMD,  8'hFF, 8'hFF,  1'b0, ST_OK});
        dir_tab.push_back('{OP_CMD,  8'h5A, 8'h00,  1'b0, ST_OK});
        dir_tab.push_back('{OP_CMD,  8'hA5, 8'hAA,  1'b0, ST_OK});
        dir_tab.push_back('{OP_CMD,  8'h80, 8'd251, 1'b0, ST_OK});
        c = crc16_update(crc16_update(16'h0000, 8'h04), 8'h11);
        dir_tab.push_back('{OP_WAKE, 8'h04,    8'h00, 1'b0, ST_OK});
        dir_tab.push_back('{OP_WAKE, 8'h11,    8'h00, 1'b0, ST_OK});
        dir_tab.push_back('{OP_WAKE, c[7:0],   8'h00, 1'b0, ST_OK});
        dir_tab.push_back('{OP_WAKE, c[15:8],  8'h00, 1'b1, ST_OK});
        c = crc16_update(crc16_update(16'h0000, 8'h04), 8'h77);
        dir_tab.push_back('{OP_RSP,  8'h04,    8'h00, 1'b0, ST_OK});
        dir_tab.push_back('{OP_RSP,  8'h77,    8'h00, 1'b0, ST_OK});
        dir_tab.push_back('{OP_RSP,  c[7:0],   8'h00, 1'b0, ST_OK});
        dir_tab.push_back('{OP_RSP,  c[15:8],  8'h00, 1'b1, ST_OK});

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[k]) begin
            send_word(dir_tab[k].op, dir_tab[k].d, dir_tab[k].plen, dir_tab[k].typed,
                      dir_tab[k].st);
        end

        for (int p = 0; p < 6; p++) begin
            drain();
            case (p)
                1:       write_all(8'd0, 8'd1, 8'd251, 8'd0);
                2:       write_all(8'd255, 8'd1, 8'd1, 8'd255);
                3:       write_all(8'($urandom), 8'd0, 8'd255, 8'($urandom));
                4:       write_all(8'($urandom), 8'd251, 8'd251, RST_WAKE_OK_CODE);
                5:       write_all(8'($urandom), 8'd9, 8'd5, 8'($urandom));
                default: ;
            endcase
            case (p % 4)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 81; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 81; end
                default: begin idle_pct = 28; stall_pct = 28; end
            endcase
            start = items_sent;
            while (items_sent - start < 44) begin
                pick = $urandom_range(99);
                if (pick < 30) begin
                    rand_command();
                end else if (pick < 60) begin
                    rand_response();
                end else if (pick < 85) begin
                    rand_wake();
                end else begin
                    repeat ($urandom_range(3, 1)) begin
                        send_word(2'($urandom), 8'($urandom), 8'($urandom), 1'b0, ST_OK);
                    end
                end
            end
        end

        drain();
        if (errors == 0) begin
            $display("tb_crypto_chip_packet_framer_checker_core OK");
        end else begin
            $display("tb_crypto_chip_packet_framer_checker_core NOT OK");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/cpfc_pkg.sv
hdl/cpfc_in_reg.sv
hdl/cpfc_core.sv
hdl/cpfc_out_buf.sv
hdl/crypto_chip_packet_framer_checker_core.sv
hdl/cpfc_checker.sv
test/tb_crypto_chip_packet_framer_checker_core.sv
